### design/i2c_sensor_measure_master_assert.svh
// Assertion macros shared by the measurement master modules
`ifndef I2C_SENSOR_MEASURE_MASTER_ASSERT_SVH
`define I2C_SENSOR_MEASURE_MASTER_ASSERT_SVH

// Condition that must hold at every clock edge outside reset
`define I2CSM_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Condition in one cycle that implies another in the next cycle
`define I2CSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/i2csm_pkg.sv
// Types, phase codes and phase tables of the I2C measurement master
package i2csm_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 20;
    localparam int MEAS_W      = 48;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_ADDRESS  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MEASURE_COMMAND = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HALF_PERIOD     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD            = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_WAIT            = 3'd4;

    localparam logic [6:0]  RST_DEVICE_ADDRESS  = 7'h44;
    localparam logic [7:0]  RST_MEASURE_COMMAND = 8'hFD;
    localparam logic [7:0]  RST_HALF_PERIOD     = 8'd2;
    localparam logic [7:0]  RST_HOLD            = 8'd5;
    localparam logic [19:0] RST_WAIT            = 20'd18000;

    // error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_WADDR_NAK = 2'd1;
    localparam logic [1:0] ERR_CMD_NAK   = 2'd2;
    localparam logic [1:0] ERR_RADDR_NAK = 2'd3;

    // sequencer phases
    localparam logic [4:0] PH_IDLE      = 5'd0;
    localparam logic [4:0] PH_WSTART_A  = 5'd1;
    localparam logic [4:0] PH_WSTART_B  = 5'd2;
    localparam logic [4:0] PH_WBIT_LO   = 5'd3;
    localparam logic [4:0] PH_WBIT_HI   = 5'd4;
    localparam logic [4:0] PH_WACK_LO   = 5'd5;
    localparam logic [4:0] PH_WACK_HI   = 5'd6;
    localparam logic [4:0] PH_WACK_HOLD = 5'd7;
    localparam logic [4:0] PH_CBIT_LO   = 5'd8;
    localparam logic [4:0] PH_CBIT_HI   = 5'd9;
    localparam logic [4:0] PH_CACK_LO   = 5'd10;
    localparam logic [4:0] PH_CACK_HI   = 5'd11;
    localparam logic [4:0] PH_CACK_HOLD = 5'd12;
    localparam logic [4:0] PH_WSTOP_A   = 5'd13;
    localparam logic [4:0] PH_WSTOP_B   = 5'd14;
    localparam logic [4:0] PH_WSTOP_C   = 5'd15;
    localparam logic [4:0] PH_STOP_A    = 5'd16;
    localparam logic [4:0] PH_STOP_B    = 5'd17;
    localparam logic [4:0] PH_STOP_C    = 5'd18;
    localparam logic [4:0] PH_CONV_WAIT = 5'd19;
    localparam logic [4:0] PH_RSTART_A  = 5'd20;
    localparam logic [4:0] PH_RSTART_B  = 5'd21;
    localparam logic [4:0] PH_RBIT_LO   = 5'd22;
    localparam logic [4:0] PH_RBIT_HI   = 5'd23;
    localparam logic [4:0] PH_RACK_LO   = 5'd24;
    localparam logic [4:0] PH_RACK_HI   = 5'd25;
    localparam logic [4:0] PH_RACK_HOLD = 5'd26;
    localparam logic [4:0] PH_DATA_LO   = 5'd27;
    localparam logic [4:0] PH_DATA_HI   = 5'd28;
    localparam logic [4:0] PH_MACK_LO   = 5'd29;
    localparam logic [4:0] PH_MACK_HI   = 5'd30;
    localparam logic [4:0] PH_LAST      = PH_MACK_HI;

    // SDA drive modes
    localparam logic [1:0] SD_REL = 2'd0;
    localparam logic [1:0] SD_LOW = 2'd1;
    localparam logic [1:0] SD_BIT = 2'd2;
    localparam logic [1:0] SD_ACK = 2'd3;

    // phase length kinds
    localparam logic [1:0] LN_HALF = 2'd0;
    localparam logic [1:0] LN_HOLD = 2'd1;
    localparam logic [1:0] LN_WAIT = 2'd2;

    localparam logic PH_SCL [32] = '{
        1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0,
        1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1,
        1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1,
        1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};

    localparam logic [1:0] PH_SDA [32] = '{
        SD_REL, SD_REL, SD_LOW, SD_BIT, SD_BIT, SD_REL, SD_REL, SD_REL,
        SD_BIT, SD_BIT, SD_REL, SD_REL, SD_REL, SD_LOW, SD_LOW, SD_REL,
        SD_LOW, SD_LOW, SD_REL, SD_REL, SD_REL, SD_LOW, SD_BIT, SD_BIT,
        SD_REL, SD_REL, SD_REL, SD_REL, SD_REL, SD_ACK, SD_ACK, SD_REL};

    localparam logic [1:0] PH_LEN [32] = '{
        LN_HALF, LN_HOLD, LN_HOLD, LN_HALF, LN_HALF, LN_HALF, LN_HALF, LN_HOLD,
        LN_HALF, LN_HALF, LN_HALF, LN_HALF, LN_HOLD, LN_HALF, LN_HOLD, LN_HALF,
        LN_HALF, LN_HOLD, LN_HALF, LN_WAIT, LN_HOLD, LN_HOLD, LN_HALF, LN_HALF,
        LN_HALF, LN_HALF, LN_HOLD, LN_HALF, LN_HALF, LN_HALF, LN_HALF, LN_HALF};

    typedef struct packed {
        logic command;
        logic sda_in;
    } in_t;

    typedef struct packed {
        logic              scl_level;
        logic              sda_pull_low;
        logic              busy_res;
        logic              done_res;
        logic [1:0]        error_code;
        logic [MEAS_W-1:0] measurement;
    } out_t;

    typedef struct packed {
        logic [6:0]  device_address;
        logic [7:0]  measure_command;
        logic [7:0]  half_period_ticks;
        logic [7:0]  hold_ticks;
        logic [19:0] wait_ticks;
    } cfg_t;

endpackage

### design/i2c_sensor_measure_master.sv
// Top level: tick input register, phase sequencer and result register
//
//  channel | signals                          | payload
//  --------+----------------------------------+-----------------------------
//  in      | in_valid / in_ready              | in_data  (command, sda_in)
//  out     | out_valid / out_ready            | out_data (bus levels, status)
//  cfg     | cfg_write_en, cfg_index          | cfg_data (20 bits, no wait)
//
// One tick per cycle while out is not stalled: a tick goes into the input
// register and is stepped through the sequencer on its way to the result register.
// Both registers can hold a transaction, so ticks flow back to back while
// out_ready is high; a stall on out holds the result and backs up to in.
// Reset puts the sequencer idle with the default bus address and timings.
module i2c_sensor_measure_master #(
    parameter int READ_BYTES = 6
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  i2csm_pkg::in_t                    in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output i2csm_pkg::out_t                   out_data,
    input  logic                              cfg_write_en,
    input  logic [i2csm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [i2csm_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import i2csm_pkg::*;

    logic s1_valid_reg;
    in_t  s1_item_reg;
    logic out_valid_reg;
    out_t out_reg;
    logic adv;
    cfg_t cfg;
    out_t step_result;

    assign adv      = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || adv;

    i2csm_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .write_en (cfg_write_en),
        .index    (cfg_index),
        .data     (cfg_data),
        .cfg      (cfg)
    );

    i2csm_seq #(
        .READ_BYTES (READ_BYTES)
    ) u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (adv),
        .item   (s1_item_reg),
        .cfg    (cfg),
        .result (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (adv)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_item_reg <= in_data;
        if (adv)
            out_reg <= step_result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`include "i2c_sensor_measure_master_assert.svh"

    `I2CSM_ASSERT_NEXT(a_tick_captured, in_valid && in_ready, s1_valid_reg,
        "accepted tick missing from input register")
    `I2CSM_ASSERT_NEXT(a_result_captured, adv, out_valid_reg,
        "stepped tick missing from result register")
    `I2CSM_ASSERT_ALWAYS(a_empty_stage_ready, s1_valid_reg || in_ready,
        "input stage empty but not ready")

endmodule

### design/i2csm_cfg.sv
// Configuration register file of the I2C measurement master
module i2csm_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             write_en,
    input  logic [i2csm_pkg::CFG_INDEX_W-1:0] index,
    input  logic [i2csm_pkg::CFG_DATA_W-1:0]  data,
    output i2csm_pkg::cfg_t                  cfg
);
    import i2csm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (write_en)
        begin
            case (index)
                REG_DEVICE_ADDRESS:  cfg_next.device_address    = data[6:0];
                REG_MEASURE_COMMAND: cfg_next.measure_command   = data[7:0];
                REG_HALF_PERIOD:     cfg_next.half_period_ticks = data[7:0];
                REG_HOLD:            cfg_next.hold_ticks        = data[7:0];
                REG_WAIT:            cfg_next.wait_ticks        = data[19:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.device_address    <= RST_DEVICE_ADDRESS;
            cfg_reg.measure_command   <= RST_MEASURE_COMMAND;
            cfg_reg.half_period_ticks <= RST_HALF_PERIOD;
            cfg_reg.hold_ticks        <= RST_HOLD;
            cfg_reg.wait_ticks        <= RST_WAIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### design/i2csm_seq.sv
// Bus phase sequencer: state registers and the per-tick step logic
module i2csm_seq #(
    parameter int READ_BYTES = 6
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  i2csm_pkg::in_t  item,
    input  i2csm_pkg::cfg_t cfg,
    output i2csm_pkg::out_t result
);
    import i2csm_pkg::*;

    localparam logic [2:0] LAST_BYTE = 3'(READ_BYTES - 1);

    logic [4:0]        phase_reg, phase_next;
    logic [19:0]       tick_reg, tick_next;
    logic [3:0]        bit_reg, bit_next;
    logic [2:0]        byte_reg, byte_next;
    logic [7:0]        shift_reg, shift_next;
    logic [MEAS_W-1:0] data_reg, data_next;
    logic              ack_reg, ack_next;
    logic [1:0]        err_reg, err_next;

    logic [4:0]  p;
    logic        busy;
    logic        pull;
    logic        done;
    logic [19:0] len;
    logic [20:0] tick_inc;
    logic [3:0]  bit_inc;
    logic [7:0]  shift_in;

    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        bit_next   = bit_reg;
        byte_next  = byte_reg;
        shift_next = shift_reg;
        data_next  = data_reg;
        ack_next   = ack_reg;
        err_next   = err_reg;
        done       = 1'b0;
        pull       = 1'b0;
        len        = 20'd1;
        shift_in   = {shift_reg[6:0], item.sda_in};
        bit_inc    = bit_reg + 4'd1;

        p = (phase_reg > PH_LAST) ? PH_IDLE : phase_reg;

        if (p == PH_IDLE && item.command)
        begin
            err_next   = ERR_NONE;
            data_next  = '0;
            ack_next   = 1'b0;
            bit_next   = '0;
            byte_next  = '0;
            shift_next = {cfg.device_address, 1'b0};
            p          = PH_WSTART_A;
            tick_next  = '0;
        end
        phase_next = p;
        busy       = (p != PH_IDLE);

        case (PH_SDA[p])
            SD_LOW:  pull = 1'b1;
            SD_BIT:  pull = !shift_next[7];
            SD_ACK:  pull = (byte_next < LAST_BYTE);
            default: pull = 1'b0;
        endcase

        case (PH_LEN[p])
            LN_WAIT: len = cfg.wait_ticks;
            LN_HOLD: len = (cfg.hold_ticks == 8'd0) ? 20'd1 : {12'd0, cfg.hold_ticks};
            default: len = (cfg.half_period_ticks == 8'd0) ? 20'd1
                                                           : {12'd0, cfg.half_period_ticks};
        endcase

        tick_inc = {1'b0, tick_next} + 21'd1;

        if (busy)
        begin
            if ((p == PH_WACK_HI || p == PH_CACK_HI || p == PH_RACK_HI) && !item.sda_in)
            begin
                ack_next = 1'b1;
            end

            if (tick_inc >= {1'b0, len})
            begin
                tick_next = '0;
                case (p)
                    PH_WBIT_HI, PH_CBIT_HI, PH_RBIT_HI:
                    begin
                        shift_next = {shift_next[6:0], 1'b0};
                        if (bit_inc >= 4'd8)
                        begin
                            bit_next   = '0;
                            ack_next   = 1'b0;
                            phase_next = p + 5'd1;
                        end
                        else
                        begin
                            bit_next   = bit_inc;
                            phase_next = p - 5'd1;
                        end
                    end
                    PH_WACK_HOLD, PH_CACK_HOLD, PH_RACK_HOLD:
                    begin
                        if (!ack_next)
                        begin
                            if (p == PH_WACK_HOLD)
                                err_next = ERR_WADDR_NAK;
                            else if (p == PH_CACK_HOLD)
                                err_next = ERR_CMD_NAK;
                            else
                                err_next = ERR_RADDR_NAK;
                            phase_next = PH_STOP_A;
                        end
                        else if (p == PH_WACK_HOLD)
                        begin
                            shift_next = cfg.measure_command;
                            bit_next   = '0;
                            phase_next = PH_CBIT_LO;
                        end
                        else if (p == PH_CACK_HOLD)
                        begin
                            phase_next = PH_WSTOP_A;
                        end
                        else
                        begin
                            shift_next = '0;
                            bit_next   = '0;
                            byte_next  = '0;
                            phase_next = PH_DATA_LO;
                        end
                    end
                    PH_WSTOP_C:
                    begin
                        if (cfg.wait_ticks == 20'd0)
                        begin
                            shift_next = {cfg.device_address, 1'b1};
                            phase_next = PH_RSTART_A;
                        end
                        else
                        begin
                            phase_next = PH_CONV_WAIT;
                        end
                    end
                    PH_CONV_WAIT:
                    begin
                        shift_next = {cfg.device_address, 1'b1};
                        phase_next = PH_RSTART_A;
                    end
                    PH_STOP_C:
                    begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                    PH_DATA_HI:
                    begin
                        shift_next = shift_in;
                        if (bit_inc >= 4'd8)
                        begin
                            data_next  = {data_reg[MEAS_W-9:0], shift_in};
                            bit_next   = '0;
                            phase_next = PH_MACK_LO;
                        end
                        else
                        begin
                            bit_next   = bit_inc;
                            phase_next = PH_DATA_LO;
                        end
                    end
                    PH_MACK_HI:
                    begin
                        if (byte_next >= LAST_BYTE)
                        begin
                            phase_next = PH_STOP_A;
                        end
                        else
                        begin
                            byte_next  = byte_next + 3'd1;
                            shift_next = '0;
                            phase_next = PH_DATA_LO;
                        end
                    end
                    default:
                    begin
                        phase_next = p + 5'd1;
                    end
                endcase
            end
            else
            begin
                tick_next = tick_inc[19:0];
            end
        end

        result.scl_level    = PH_SCL[p];
        result.sda_pull_low = pull;
        result.busy_res     = busy;
        result.done_res     = done;
        result.error_code   = err_next;
        result.measurement  = data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tick_reg  <= '0;
            bit_reg   <= '0;
            byte_reg  <= '0;
            shift_reg <= '0;
            data_reg  <= '0;
            ack_reg   <= 1'b0;
            err_reg   <= ERR_NONE;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            byte_reg  <= byte_next;
            shift_reg <= shift_next;
            data_reg  <= data_next;
            ack_reg   <= ack_next;
            err_reg   <= err_next;
        end
    end

`include "i2c_sensor_measure_master_assert.svh"

    `I2CSM_ASSERT_NEXT(a_done_returns_idle, step && result.done_res,
        phase_reg == PH_IDLE, "done pulse did not return the sequencer to idle")
    `I2CSM_ASSERT_ALWAYS(a_bit_count_range, bit_reg < 4'd8,
        "bit counter left its byte range")
    `I2CSM_ASSERT_ALWAYS(a_idle_lines_released,
        result.busy_res || (result.scl_level && !result.sda_pull_low),
        "bus lines not released while idle")

endmodule
